[hw/rtl/trst_pkg.sv]
`default_nettype none

package trst_pkg;

	// Connection states as reported on conn_state
	typedef enum logic [1:0] {
		ST_CLOSED     = 2'd0,
		ST_SYN_SENT   = 2'd1,
		ST_ESTAB      = 2'd2,
		ST_CLOSE_WAIT = 2'd3
	} conn_state_t;

	// Input opcodes
	typedef enum logic [1:0] {
		OP_SEGMENT = 2'd0,
		OP_OPEN    = 2'd1,
		OP_CLOSE   = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	// Configuration register indexes
	localparam logic [1:0] CFG_PEER_ADDRESS = 2'd0;
	localparam logic [1:0] CFG_PEER_PORT    = 2'd1;
	localparam logic [1:0] CFG_OWN_PORT     = 2'd2;

	// Flag bits of the TCP flag byte
	localparam logic [7:0] FL_FIN    = 8'h01;
	localparam logic [7:0] FL_RST    = 8'h04;
	localparam logic [7:0] FL_ACK    = 8'h10;
	localparam logic [7:0] FL_SYNACK = 8'h12;

	localparam logic [15:0] MIN_SEG_BYTES = 16'd20;

	// Depth of the queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// One classified event, as the front hands it to the back
	typedef struct packed {
		op_t         op;
		logic        hdr_ok;     // length and addressing checks passed
		logic        rst;
		logic        synack;
		logic        ack_flag;
		logic        fin;
		logic        data_nz;    // segment carries payload
		logic        full_take;  // whole payload fits in free space
		logic [15:0] take_len;   // min(payload, free space)
		logic [31:0] seq;        // seg_seq, or initial_seq for an open
		logic [31:0] ack;
		logic [31:0] snext;
		logic [31:0] seq_end;    // seg_seq + payload length
	} event_t;

	// Configuration seen by the front
	typedef struct packed {
		logic [31:0] peer_address;
		logic [15:0] peer_port;
		logic [15:0] own_port;
	} conn_cfg_t;

endpackage

`default_nettype wire

[hw/rtl/trst_front.sv]
`default_nettype none

module trst_front import trst_pkg::*; #(
	parameter logic [15:0] ROOM_MAX = 16'hFFFF
) (
	input  wire logic [1:0]  opcode,
	input  wire logic [31:0] src_ip,
	input  wire logic [15:0] seg_sport,
	input  wire logic [15:0] seg_dport,
	input  wire logic [31:0] seg_seq,
	input  wire logic [31:0] seg_ack,
	input  wire logic [7:0]  tcp_flags,
	input  wire logic [3:0]  header_words,
	input  wire logic [15:0] seg_len,
	input  wire logic [31:0] send_next,
	input  wire logic [15:0] buffer_free,
	input  wire logic [31:0] initial_seq,
	input  wire conn_cfg_t   cfg,
	output event_t           evt
);

	logic [15:0] hdr_bytes;
	logic [15:0] data_len;
	logic [15:0] room;
	logic [15:0] take;
	op_t         op;

	always_comb begin
		op        = op_t'(opcode);
		hdr_bytes = {10'd0, header_words, 2'b00};
		data_len  = (seg_len > hdr_bytes) ? (seg_len - hdr_bytes) : 16'd0;
		room      = (buffer_free > ROOM_MAX) ? ROOM_MAX : buffer_free;
		take      = (data_len < room) ? data_len : room;

		evt.op        = op;
		evt.hdr_ok    = (seg_len >= MIN_SEG_BYTES) && (src_ip == cfg.peer_address)
			&& (seg_sport == cfg.peer_port) && (seg_dport == cfg.own_port);
		evt.rst       = |(tcp_flags & FL_RST);
		evt.synack    = (tcp_flags & FL_SYNACK) == FL_SYNACK;
		evt.ack_flag  = |(tcp_flags & FL_ACK);
		evt.fin       = |(tcp_flags & FL_FIN);
		evt.data_nz   = data_len != 16'd0;
		evt.full_take = take == data_len;
		evt.take_len  = take;
		// an open carries its initial sequence in the seq slot
		evt.seq       = (op == OP_OPEN) ? initial_seq : seg_seq;
		evt.ack       = seg_ack;
		evt.snext     = send_next;
		evt.seq_end   = seg_seq + {16'd0, data_len};
	end

endmodule

`default_nettype wire

[hw/rtl/trst_queue.sv]
`default_nettype none

module trst_queue import trst_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire event_t push_data,
	input  wire logic   pop,
	output logic        full,
	output logic        not_empty,
	output event_t      head
);

	event_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full      = count_q == QCNT_W'(QDEPTH);
	assign not_empty = count_q != '0;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[hw/rtl/trst_back.sv]
`default_nettype none

module trst_back import trst_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   evt_valid,
	input  wire event_t evt,
	output logic        evt_pop,
	output logic        res_valid,
	input  wire logic   res_stall,
	output logic [15:0] accepted_bytes,
	output logic [1:0]  ack_count,
	output logic [1:0]  conn_state,
	output logic [31:0] rcv_next,
	output logic [31:0] send_unacked,
	output logic        fin_seen,
	output logic        reset_seen,
	output logic        dropped
);

	conn_state_t state_q, state_d;
	logic [31:0] expect_q, expect_d;
	logic [31:0] una_q, una_d;
	logic        fin_q, fin_d;
	logic        rst_q, rst_d;

	logic        valid_q;
	logic [15:0] taken_q, taken_d;
	logic [1:0]  acks_q, acks_d;
	logic        drop_q, drop_d;

	logic        seq_eq;
	logic        fin_ok;
	logic        ack_fwd;
	logic [31:0] ack_dist;
	logic [31:0] win_dist;
	logic [15:0] take_eff;

	// take the next event whenever the result slot is free or drains now
	assign evt_pop = evt_valid && (!valid_q || !res_stall);

	always_comb begin
		state_d  = state_q;
		expect_d = expect_q;
		una_d    = una_q;
		fin_d    = fin_q;
		rst_d    = rst_q;
		taken_d  = 16'd0;
		acks_d   = 2'd0;
		drop_d   = 1'b0;

		seq_eq   = evt.seq == expect_q;
		ack_dist = evt.ack - una_q;
		win_dist = evt.snext - una_q;
		ack_fwd  = evt.ack_flag && (ack_dist <= win_dist);
		take_eff = seq_eq ? evt.take_len : 16'd0;
		fin_ok   = evt.fin && (seq_eq ? evt.full_take : (evt.seq_end == expect_q));

		unique case (evt.op)
			OP_SEGMENT: begin
				if (!evt.hdr_ok || state_q == ST_CLOSED) begin
					drop_d = 1'b1;
				end else if (evt.rst) begin
					rst_d   = 1'b1;
					state_d = ST_CLOSED;
				end else if (state_q == ST_SYN_SENT) begin
					if (evt.synack) begin
						expect_d = evt.seq + 32'd1;
						una_d    = evt.ack;
						state_d  = ST_ESTAB;
						acks_d   = 2'd1;
					end
				end else begin
					if (ack_fwd) begin
						una_d = evt.ack;
					end
					taken_d  = take_eff;
					expect_d = expect_q + {16'd0, take_eff} + {31'd0, fin_ok};
					acks_d   = {1'b0, evt.data_nz} + {1'b0, fin_ok};
					if (fin_ok) begin
						fin_d   = 1'b1;
						state_d = ST_CLOSE_WAIT;
					end
				end
			end
			OP_OPEN: begin
				state_d  = ST_SYN_SENT;
				expect_d = 32'd0;
				una_d    = evt.seq;
				fin_d    = 1'b0;
				rst_d    = 1'b0;
			end
			OP_CLOSE: begin
				state_d = ST_CLOSED;
			end
			OP_NONE: begin
				state_d = state_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLOSED;
			expect_q <= '0;
			una_q    <= '0;
			fin_q    <= 1'b0;
			rst_q    <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (evt_pop) begin
				state_q  <= state_d;
				expect_q <= expect_d;
				una_q    <= una_d;
				fin_q    <= fin_d;
				rst_q    <= rst_d;
				valid_q  <= 1'b1;
			end else if (!res_stall) begin
				valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (evt_pop) begin
			taken_q <= taken_d;
			acks_q  <= acks_d;
			drop_q  <= drop_d;
		end
	end

	// state registers double as the result's state fields
	assign res_valid      = valid_q;
	assign accepted_bytes = taken_q;
	assign ack_count      = acks_q;
	assign conn_state     = state_q;
	assign rcv_next       = expect_q;
	assign send_unacked   = una_q;
	assign fin_seen       = fin_q;
	assign reset_seen     = rst_q;
	assign dropped        = drop_q;

endmodule

`default_nettype wire

[hw/rtl/tcp_receive_segment_tracker.sv]
`default_nettype none

// channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+-----------------------------------------
// in       | into      | in_valid / in_stall   | opcode, segment header, send_next, ...
// out      | out of    | out_valid / out_stall | accepted_bytes, ack_count, state fields
// cfg      | into      | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
// One word in, one word out. A word taken on the input waits in the queue, is applied by
// the back when it pops it and shows on out_valid from then on.
// Sustained rate is one word per cycle while out_stall stays low, bound by the back's state update.
// in_stall rises only when the two-entry queue is full, i.e. after out_stall backs it up.
// arst_n clears connection state, config registers, queue and result valid to zero.

module tcp_receive_segment_tracker import trst_pkg::*; #(
	parameter int BUFFER_BYTES = 65536
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  opcode,
	input  wire logic [31:0] src_ip,
	input  wire logic [15:0] seg_sport,
	input  wire logic [15:0] seg_dport,
	input  wire logic [31:0] seg_seq,
	input  wire logic [31:0] seg_ack,
	input  wire logic [7:0]  tcp_flags,
	input  wire logic [3:0]  header_words,
	input  wire logic [15:0] seg_len,
	input  wire logic [31:0] send_next,
	input  wire logic [15:0] buffer_free,
	input  wire logic [31:0] initial_seq,
	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      accepted_bytes,
	output logic [1:0]       ack_count,
	output logic [1:0]       conn_state,
	output logic [31:0]      rcv_next,
	output logic [31:0]      send_unacked,
	output logic             fin_seen,
	output logic             reset_seen,
	output logic             dropped,
	// configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	// Ring keeps one slot empty, so usable space tops out one below the size
	localparam logic [15:0] ROOM_MAX = 16'(BUFFER_BYTES - 1);

	conn_cfg_t cfg_q;
	event_t    front_evt;
	event_t    queue_head;
	logic      queue_full;
	logic      queue_nonempty;
	logic      queue_pop;
	logic      in_take;

	// Config writes are registered directly; never hold them off
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PEER_ADDRESS: cfg_q.peer_address <= cfg_data;
				CFG_PEER_PORT:    cfg_q.peer_port    <= cfg_data[15:0];
				CFG_OWN_PORT:     cfg_q.own_port     <= cfg_data[15:0];
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	// Front: classify the word against the config; nothing here depends on
	// connection state, so it runs ahead of the back freely
	trst_front #(
		.ROOM_MAX(ROOM_MAX)
	) u_front (
		.opcode      (opcode),
		.src_ip      (src_ip),
		.seg_sport   (seg_sport),
		.seg_dport   (seg_dport),
		.seg_seq     (seg_seq),
		.seg_ack     (seg_ack),
		.tcp_flags   (tcp_flags),
		.header_words(header_words),
		.seg_len     (seg_len),
		.send_next   (send_next),
		.buffer_free (buffer_free),
		.initial_seq (initial_seq),
		.cfg         (cfg_q),
		.evt         (front_evt)
	);

	// Stall the input only on a full queue; a push and a pop may share a cycle
	// only when there is room, so back-to-back flow needs one entry in flight
	assign in_stall = queue_full;
	assign in_take  = in_valid && !in_stall;

	trst_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_take),
		.push_data(front_evt),
		.pop      (queue_pop),
		.full     (queue_full),
		.not_empty(queue_nonempty),
		.head     (queue_head)
	);

	// Back: apply the event to the connection state and hold the result
	trst_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.evt_valid     (queue_nonempty),
		.evt           (queue_head),
		.evt_pop       (queue_pop),
		.res_valid     (out_valid),
		.res_stall     (out_stall),
		.accepted_bytes(accepted_bytes),
		.ack_count     (ack_count),
		.conn_state    (conn_state),
		.rcv_next      (rcv_next),
		.send_unacked  (send_unacked),
		.fin_seen      (fin_seen),
		.reset_seen    (reset_seen),
		.dropped       (dropped)
	);

endmodule

`default_nettype wire
